// File: design/amf_pkg.sv
// Shared types and constants for the adaptive median filter core.
// No dependencies; imported by amf_median, the top level and the testbench.
`timescale 1ns / 1ps

package amf_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int OCOL_W      = 10;
    localparam int CFG_W_W     = 11;
    localparam int CFG_H_W     = 13;
    localparam int SIZE_W      = 13;
    localparam int MAX_WIDTH_D = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 5;
    localparam int WIN_N       = 25;
    localparam int SMALL_N     = 9;
    localparam int CENTER_IDX  = 12;
    localparam int SLOTS       = 4;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 13'd480;

    // register index decoded from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;
    typedef logic [SMALL_N-1:0][PIX_W-1:0] small_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } out_meta_t;

    // 3x3 entries inside the 5x5 window, row-major
    localparam int SMALL_IDX [SMALL_N] = '{6, 7, 8, 11, 12, 13, 16, 17, 18};

endpackage

// File: design/amf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read and write of one entry in a cycle returns the old data.
`timescale 1ns / 1ps

module amf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/amf_median.sv
// Rank-based min/median/max pipeline for the 3x3 and 5x5 windows and the
// adaptive decision; owns the output register. Depends on amf_pkg.
`timescale 1ns / 1ps

module amf_median
    import amf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  window_t   win,
    input  out_meta_t in_meta,
    output logic      out_valid,
    output pixel_t    pixel_out,
    output out_meta_t out_meta
);

    // stage A: pairwise compare matrices (stable order for ties)
    logic                                a_valid_reg;
    window_t                             a_win_reg;
    out_meta_t                           a_meta_reg;
    logic [WIN_N-1:0][WIN_N-1:0]         a_lt25_reg, a_lt25_next;
    logic [SMALL_N-1:0][SMALL_N-1:0]     a_lt9_reg, a_lt9_next;

    // stage B: ranks
    logic                                b_valid_reg;
    window_t                             b_win_reg;
    out_meta_t                           b_meta_reg;
    logic [WIN_N-1:0][4:0]               b_rk25_reg, b_rk25_next;
    logic [SMALL_N-1:0][3:0]             b_rk9_reg, b_rk9_next;

    // stage C: selected order statistics
    logic                                c_valid_reg;
    pixel_t                              c_ctr_reg;
    out_meta_t                           c_meta_reg;
    pixel_t c_lo9_reg, c_md9_reg, c_hi9_reg, c_lo25_reg, c_md25_reg, c_hi25_reg;
    pixel_t c_lo9_next, c_md9_next, c_hi9_next, c_lo25_next, c_md25_next, c_hi25_next;

    logic      out_valid_reg;
    pixel_t    pix_reg, pix_next;
    out_meta_t meta_reg;

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            for (int j = 0; j < WIN_N; j++)
            begin
                if (j < i)
                    a_lt25_next[i][j] = (win[j] <= win[i]);
                else if (j > i)
                    a_lt25_next[i][j] = (win[j] < win[i]);
                else
                    a_lt25_next[i][j] = 1'b0;
            end
        end
        for (int i = 0; i < SMALL_N; i++)
        begin
            for (int j = 0; j < SMALL_N; j++)
            begin
                if (j < i)
                    a_lt9_next[i][j] = (win[SMALL_IDX[j]] <= win[SMALL_IDX[i]]);
                else if (j > i)
                    a_lt9_next[i][j] = (win[SMALL_IDX[j]] < win[SMALL_IDX[i]]);
                else
                    a_lt9_next[i][j] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            b_rk25_next[i] = '0;
            for (int j = 0; j < WIN_N; j++)
            begin
                b_rk25_next[i] = b_rk25_next[i] + 5'(a_lt25_reg[i][j]);
            end
        end
        for (int i = 0; i < SMALL_N; i++)
        begin
            b_rk9_next[i] = '0;
            for (int j = 0; j < SMALL_N; j++)
            begin
                b_rk9_next[i] = b_rk9_next[i] + 4'(a_lt9_reg[i][j]);
            end
        end
    end

    // ranks are a permutation, so OR of the matching entries picks one value
    always_comb
    begin
        c_lo25_next = '0;
        c_md25_next = '0;
        c_hi25_next = '0;
        c_lo9_next  = '0;
        c_md9_next  = '0;
        c_hi9_next  = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            if (b_rk25_reg[i] == 5'(0))
                c_lo25_next = c_lo25_next | b_win_reg[i];
            if (b_rk25_reg[i] == 5'(WIN_N / 2))
                c_md25_next = c_md25_next | b_win_reg[i];
            if (b_rk25_reg[i] == 5'(WIN_N - 1))
                c_hi25_next = c_hi25_next | b_win_reg[i];
        end
        for (int i = 0; i < SMALL_N; i++)
        begin
            if (b_rk9_reg[i] == 4'(0))
                c_lo9_next = c_lo9_next | b_win_reg[SMALL_IDX[i]];
            if (b_rk9_reg[i] == 4'(SMALL_N / 2))
                c_md9_next = c_md9_next | b_win_reg[SMALL_IDX[i]];
            if (b_rk9_reg[i] == 4'(SMALL_N - 1))
                c_hi9_next = c_hi9_next | b_win_reg[SMALL_IDX[i]];
        end
    end

    always_comb
    begin
        if (c_lo9_reg < c_md9_reg && c_md9_reg < c_hi9_reg)
        begin
            pix_next = (c_lo9_reg < c_ctr_reg && c_ctr_reg < c_hi9_reg) ? c_ctr_reg
                                                                         : c_md9_reg;
        end
        else if (c_lo25_reg < c_md25_reg && c_md25_reg < c_hi25_reg
                 && c_lo25_reg < c_ctr_reg && c_ctr_reg < c_hi25_reg)
        begin
            pix_next = c_ctr_reg;
        end
        else
        begin
            pix_next = c_md25_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_win_reg  <= win;
            a_meta_reg <= in_meta;
            a_lt25_reg <= a_lt25_next;
            a_lt9_reg  <= a_lt9_next;
            b_win_reg  <= a_win_reg;
            b_meta_reg <= a_meta_reg;
            b_rk25_reg <= b_rk25_next;
            b_rk9_reg  <= b_rk9_next;
            c_ctr_reg  <= b_win_reg[CENTER_IDX];
            c_meta_reg <= b_meta_reg;
            c_lo9_reg  <= c_lo9_next;
            c_md9_reg  <= c_md9_next;
            c_hi9_reg  <= c_hi9_next;
            c_lo25_reg <= c_lo25_next;
            c_md25_reg <= c_md25_next;
            c_hi25_reg <= c_hi25_next;
            pix_reg    <= pix_next;
            meta_reg   <= c_meta_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pix_reg;
    assign out_meta  = meta_reg;

endmodule

// File: design/adaptive_median_filter_3x3_5x5_core.sv
// Top level of the adaptive median filter: APB registers, raster counters,
// four line-store RAMs, 5x5 window. Depends on amf_pkg, amf_ram, amf_median.
`timescale 1ns / 1ps

// Adaptive 3x3/5x5 median filter for 8-bit grey pixels in raster order.
// One pixel is taken per clock unless the output stalls; a pixel whose
// window is centred at least two pixels from every edge yields one item after
// line store read, window shift, compare, rank, select; border centres yield
// none. The rate is set by the line-store RAMs: one read of all four rows
// and one write per pixel, on four separate RAMs of MAX_WIDTH entries each.
// A stall on the output holds the whole pipeline. Sizes are clamped to
// 5..MAX_WIDTH columns and 5..4096 rows and should be written while idle.

module adaptive_median_filter_3x3_5x5_core
    import amf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_D
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel_in,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   pixel_out,
    output logic [ROW_W-1:0]   center_row,
    output logic [OCOL_W-1:0]  center_col,
    output logic               frame_last
);

    localparam int CA_W = $clog2(MAX_WIDTH);

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [SIZE_W-1:0]  w_eff, h_eff, w_ext, h_ext;

    logic [CA_W-1:0]  col_reg, col_next, c_cur;
    logic [ROW_W-1:0] row_reg, row_next, r_cur;
    logic [SIZE_W-1:0] c_ext, r_ext;

    logic acc, adv, emit, last;
    logic [SLOTS-1:0] ram_we;
    pixel_t           ram_rd [SLOTS];

    logic       s1_valid_reg, s1_emit_reg, s2_valid_reg;
    logic [1:0] s1_slot_reg;
    pixel_t     s1_px_reg;
    out_meta_t  s1_meta_reg, s2_meta_reg, acc_meta, med_meta;
    window_t    win_reg, win_next;
    logic [SIZE_W-1:0] col_m2;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        w_ext = SIZE_W'(width_reg);
        h_ext = SIZE_W'(height_reg);
        if (w_ext < SIZE_W'(MIN_SIZE))
            w_eff = SIZE_W'(MIN_SIZE);
        else if (w_ext > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext < SIZE_W'(MIN_SIZE))
            h_eff = SIZE_W'(MIN_SIZE);
        else if (h_ext > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    // ---------------- raster position ----------------
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    always_comb
    begin
        c_cur = frame_start ? '0 : col_reg;
        r_cur = frame_start ? '0 : row_reg;
        c_ext = SIZE_W'(c_cur);
        r_ext = SIZE_W'(r_cur);
        emit  = (r_ext >= SIZE_W'(4)) && (c_ext >= SIZE_W'(4))
                && (r_ext < h_eff) && (c_ext < w_eff);
        last  = (r_ext == h_eff - SIZE_W'(1)) && (c_ext == w_eff - SIZE_W'(1));
        if (c_ext + SIZE_W'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (r_ext + SIZE_W'(1) >= h_eff) ? '0 : r_cur + ROW_W'(1);
        end
        else
        begin
            col_next = c_cur + CA_W'(1);
            row_next = r_cur;
        end
        col_m2        = c_ext - SIZE_W'(2);
        acc_meta.row  = r_cur - ROW_W'(2);
        acc_meta.col  = col_m2[OCOL_W-1:0];
        acc_meta.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line store: one RAM per row slot ----------------
    genvar gs;
    generate
        for (gs = 0; gs < SLOTS; gs++)
        begin : g_line
            assign ram_we[gs] = acc && (r_cur[1:0] == 2'(gs));
            amf_ram #(
                .WIDTH (PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we[gs]),
                .waddr (c_cur),
                .wdata (pixel_in),
                .re    (acc),
                .raddr (c_cur),
                .rdata (ram_rd[gs])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s1_emit_reg  <= in_valid && emit;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_slot_reg <= r_cur[1:0];
            s1_px_reg   <= pixel_in;
            s1_meta_reg <= acc_meta;
        end
        if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ---------------- 5x5 window ----------------
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                win_next[k * 5 + m] = win_reg[k * 5 + m + 1];
            end
        end
        // slot (r+k)&3 holds row r-4+k
        for (int k = 0; k < SLOTS; k++)
        begin
            win_next[k * 5 + 4] = ram_rd[2'(s1_slot_reg + 2'(k))];
        end
        win_next[WIN_N - 1] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (adv && s1_valid_reg)
            win_reg <= win_next;
    end

    amf_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg),
        .win       (win_reg),
        .in_meta   (s2_meta_reg),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .out_meta  (med_meta)
    );

    assign center_row = med_meta.row;
    assign center_col = med_meta.col;
    assign frame_last = med_meta.last;

    // ---------------- checks ----------------
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        acc && frame_start |=> col_reg == CA_W'(1) && row_reg == '0)
        else $error("frame start did not restart position");

    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> $onehot(ram_we))
        else $error("line store write not to exactly one slot");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |-> ram_we == '0)
        else $error("line store written without an item");

    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> center_row >= ROW_W'(2))
        else $error("border row emitted");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for adaptive_median_filter_3x3_5x5_core.
// Depends on amf_pkg and the core RTL; streams frames and checks each filtered pixel.
`timescale 1ns / 1ps

module tb_top;
    import amf_pkg::*;

    typedef struct {
        pixel_t pix;
        logic   fs;
    } pixel_item_t;

    typedef struct {
        pixel_t            pix;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } filtered_t;

    typedef pixel_t pix_arr_t [WIN_N];

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pixel_t             pixel_in = '0;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pixel_t             pixel_out;
    logic [ROW_W-1:0]   center_row;
    logic [OCOL_W-1:0]  center_col;
    logic               frame_last;

    adaptive_median_filter_3x3_5x5_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_in(pixel_in), .frame_start(frame_start),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_out(pixel_out), .center_row(center_row),
        .center_col(center_col), .frame_last(frame_last)
    );

    always #2 clk = ~clk;

    pixel_item_t pending_pixels[$];
    filtered_t   expected_pixels[$];

    // filter state mirrored in the testbench
    pixel_t line_mem [SLOTS][MAX_WIDTH_D];
    pixel_t win [WIN_N];
    int     pos_col = 0;
    int     pos_row = 0;
    int     cfg_width = 640;
    int     cfg_height = 480;

    int  errors = 0;
    int  items_in = 0;
    int  results_out = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  phases = 0;

    initial begin
        for (int s = 0; s < SLOTS; s++)
            for (int c = 0; c < MAX_WIDTH_D; c++)
                line_mem[s][c] = '0;
        for (int k = 0; k < WIN_N; k++)
            win[k] = '0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // min < med < max test over the first n entries; res gets med or centre
    function automatic bit rank_test(input pix_arr_t v, input int n, input pixel_t ctr,
                                     output pixel_t res);
        pixel_t t;
        pixel_t lo;
        pixel_t hi;
        pixel_t med;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n - 1 - i; j++)
                if (v[j] > v[j+1]) begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
        lo = v[0];
        hi = v[n-1];
        med = v[n/2];
        res = med;
        if (lo < med && med < hi) begin
            if (lo < ctr && ctr < hi)
                res = ctr;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic pixel_t adaptive_median();
        pix_arr_t sm;
        pixel_t   res;
        for (int k = 0; k < WIN_N; k++)
            sm[k] = '0;
        for (int k = 0; k < SMALL_N; k++)
            sm[k] = win[(k / 3 + 1) * 5 + (k % 3) + 1];
        if (rank_test(sm, SMALL_N, win[CENTER_IDX], res))
            return res;
        void'(rank_test(win, WIN_N, win[CENTER_IDX], res));
        return res;
    endfunction

    // advance the mirrored filter by one pixel, queue a result if one is due
    function automatic void predict_pixel(input pixel_t px, input logic fs);
        int     w;
        int     h;
        int     r;
        int     c;
        pixel_t colv [5];
        filtered_t e;
        w = cfg_width < MIN_SIZE ? MIN_SIZE : (cfg_width > MAX_WIDTH_D ? MAX_WIDTH_D : cfg_width);
        h = cfg_height < MIN_SIZE ? MIN_SIZE
            : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
        if (fs) begin
            pos_col = 0;
            pos_row = 0;
        end
        r = pos_row;
        c = pos_col;
        if (c < MAX_WIDTH_D) begin
            for (int k = 0; k < 4; k++)
                colv[k] = line_mem[(r + k) & 3][c];
            colv[4] = px;
            line_mem[r & 3][c] = px;
        end else begin
            for (int k = 0; k < 5; k++)
                colv[k] = px;
        end
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 4; j++)
                win[k*5 + j] = win[k*5 + j + 1];
            win[k*5 + 4] = colv[k];
        end
        if (r >= 4 && c >= 4 && r < h && c < w) begin
            e.pix  = adaptive_median();
            e.row  = ROW_W'(r - 2);
            e.col  = OCOL_W'(c - 2);
            e.last = (r == h - 1 && c == w - 1);
            expected_pixels.push_back(e);
        end
        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // sender
    always @(posedge clk) begin
        pixel_item_t it;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                items_in++;
                predict_pixel(pixel_in, frame_start);
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    it = pending_pixels.pop_front();
                    pixel_in <= it.pix;
                    frame_start <= it.fs;
                    in_valid <= 1'b1;
                    in_gap <= quiet ? 0 : gap_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off while the sender keeps offering
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && results_out >= 40) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    out_gap <= gap_len();
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        filtered_t e;
        if (rst_n && out_valid && !out_stall) begin
            results_out++;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected item pix=%0d row=%0d col=%0d last=%0b",
                         $time, pixel_out, center_row, center_col, frame_last);
            end else begin
                e = expected_pixels.pop_front();
                if (pixel_out !== e.pix) begin
                    errors++;
                    $display("%0t: pixel_out expected %0d got %0d", $time, e.pix, pixel_out);
                end
                if (center_row !== e.row) begin
                    errors++;
                    $display("%0t: center_row expected %0d got %0d", $time, e.row, center_row);
                end
                if (center_col !== e.col) begin
                    errors++;
                    $display("%0t: center_col expected %0d got %0d", $time, e.col, center_col);
                end
                if (frame_last !== e.last) begin
                    errors++;
                    $display("%0t: frame_last expected %0b got %0b", $time, e.last, frame_last);
                end
            end
        end
    end

    // watchdog on progress, and toggling of calm stretches
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 299) == 0)
                quiet <= ~quiet;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic idx, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_WIDTH)
            cfg_width = value & 32'h7FF;
        else
            cfg_height = value & 32'h1FFF;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pixel value by content style: uniform, extremes-heavy, or narrow flat
    function automatic pixel_t gen_pixel(input int style, input int base);
        int r;
        r = $urandom_range(0, 9);
        case (style)
            0: return pixel_t'($urandom_range(0, 255));
            1: return r < 3 ? 8'd0 : (r < 6 ? 8'd255 : pixel_t'($urandom_range(0, 255)));
            default: return pixel_t'(base + $urandom_range(0, 2));
        endcase
    endfunction

    task automatic run_frame(input int w, input int h, input int n, input int style,
                             input bit noisy);
        pixel_item_t it;
        int base;
        wait_idle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        phases++;
        base = $urandom_range(0, 253);
        for (int i = 0; i < n; i++) begin
            it.pix = gen_pixel(style, base);
            it.fs = (i == 0) || (noisy && $urandom_range(0, 199) == 0);
            pending_pixels.push_back(it);
        end
    endtask

    initial begin
        int rand_items;
        int w;
        int h;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // sizes below the minimum clamp to 5x5
        run_frame(0, 3, 25, 1, 1'b0);
        run_frame(2, 0, 25, 2, 1'b0);
        // oversized settings clamp; short partial first row
        run_frame(2047, 8191, 30, 0, 1'b0);
        // wider rows, long enough to fill up during the hold-off
        run_frame(40, 6, 240, 0, 1'b0);
        // frames back to back with no frame start in between
        run_frame(5, 5, 75, 0, 1'b0);
        rand_items = 0;
        while (rand_items < 700) begin
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 9);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
            run_frame(w, h, n, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
            rand_items += n;
        end
        wait_idle();
        $display("run: %0d pixels over %0d size settings, %0d filtered items checked",
                 items_in, phases, results_out);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
